@@ sv/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define SPS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ sv/sps_pkg.sv @@
package sps_pkg;

    // Field widths of the stream payloads.
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 10;
    localparam int POS_W    = 12;
    localparam int SIZE_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    // Width of the shared arithmetic unit.
    localparam int ALU_W = 18;

    // Operation kinds.
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

endpackage

@@ sv/sps_ram.sv @@
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sps_alu.sv @@
module sps_alu (
    input  sps_pkg::t_alu_req         i_req,
    output logic [sps_pkg::ALU_W-1:0] o_res
);

    // Shared adder and subtractor for offsets and sizes.
    always_comb begin
        unique case (i_req.op)
            sps_pkg::ALU_ADD: o_res = i_req.a + i_req.b;
            sps_pkg::ALU_SUB: o_res = i_req.a - i_req.b;
            default:          o_res = i_req.a;
        endcase
    end

endmodule

@@ sv/slotted_page_store_unit.sv @@
// Slotted page store: objects packed down from the page end, one slot per object.
// Add gives a registered result on acceptance; read passes the slot, size and page states.
// Remove of the last slot ends in the size state, else it moves bytes on the page ports,
// then shifts slots on the slot ports; reads and removes of slot 0 skip the upper slot read.
// One transaction is in work at a time; the next is taken the cycle after the result leaves.
// Synchronous active-low reset empties the page; stored bytes are not cleared.
module slotted_page_store_unit #(
    parameter int PAGE_BYTES   = 4096,
    parameter int MAX_SLOTS    = 1024,
    parameter int HEADER_BYTES = 4,
    parameter int SLOT_BYTES   = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index, byte_position, object_size, data_byte, zero fill
    input  logic [sps_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic [sps_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // slot_number, read_byte, stored_size, free_bytes, entry_count, zero fill
    output logic [sps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic [sps_pkg::STATUS_W-1:0]       m_axis_tuser
);

    localparam int OW = $clog2(PAGE_BYTES + 1);
    localparam int AW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int FW = OW + CW + 5;
    localparam int EW = ((OW > sps_pkg::SIZE_W) ? OW : sps_pkg::SIZE_W) + 2;
    localparam int XW = CW + sps_pkg::INDEX_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT_A,
        S_SLOT_B,
        S_SIZE,
        S_PAGE,
        S_CPY_RD,
        S_CPY_WR,
        S_SL_RD,
        S_SL_WR
    } t_state;

    // Input fields.
    logic [sps_pkg::KIND_W-1:0]  w_kind;
    logic [sps_pkg::INDEX_W-1:0] w_idx;
    logic [sps_pkg::POS_W-1:0]   w_pos;
    logic [sps_pkg::SIZE_W-1:0]  w_size;
    logic [sps_pkg::BYTE_W-1:0]  w_data;

    assign w_kind = s_axis_tuser;
    assign w_idx  = s_axis_tdata[9:0];
    assign w_pos  = s_axis_tdata[21:10];
    assign w_size = s_axis_tdata[34:22];
    assign w_data = s_axis_tdata[42:35];

    // Control and payload registers.
    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [OW-1:0]               r_last_off, n_last_off;
    logic                        r_pend, n_pend;
    logic [OW-1:0]               r_pend_off, n_pend_off;
    logic [sps_pkg::SIZE_W-1:0]  r_pend_size, n_pend_size;
    logic                        r_is_read, n_is_read;
    logic [SW-1:0]               r_idx, n_idx;
    logic [sps_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [OW-1:0]               r_off_i, n_off_i;
    logic [OW-1:0]               r_top, n_top;
    logic [OW-1:0]               r_size, n_size;
    logic [OW-1:0]               r_k, n_k;
    logic [SW-1:0]               r_i, n_i;
    logic                        r_m_valid, n_m_valid;
    logic [sps_pkg::OUT_DATA_W-1:0] r_m_data, n_m_data;
    logic [sps_pkg::STATUS_W-1:0]   r_m_user, n_m_user;

    // Result fields of the transaction that finishes in this cycle.
    logic                        w_done;
    logic [sps_pkg::STATUS_W-1:0] w_status;
    logic [sps_pkg::INDEX_W-1:0] w_slot;
    logic [sps_pkg::BYTE_W-1:0]  w_rbyte;
    logic [OW-1:0]               w_ssize;

    // Memory ports.
    logic                        w_pg_we;
    logic [AW-1:0]               w_pg_waddr, w_pg_raddr;
    logic [sps_pkg::BYTE_W-1:0]  w_pg_wdata, w_pg_rdata;
    logic                        w_sl_we;
    logic [SW-1:0]               w_sl_waddr, w_sl_raddr;
    logic [OW-1:0]               w_sl_wdata, w_sl_rdata;

    // Shared arithmetic unit.
    sps_pkg::t_alu_req           w_alu_req;
    logic [sps_pkg::ALU_W-1:0]   w_alu_res;

    logic                        w_accept;
    logic [OW-1:0]               w_free_cur, w_free_next;
    logic [OW-1:0]               w_offs;
    logic [OW-1:0]               w_last_slot;

    function automatic logic [OW-1:0] free_of(input logic [OW-1:0] lo,
                                              input logic [CW-1:0] cnt);
        logic signed [FW-1:0] f;
        f = $signed(FW'(lo)) - $signed(FW'(HEADER_BYTES))
            - $signed(FW'(SLOT_BYTES) * FW'(cnt));
        return f[FW-1] ? '0 : f[OW-1:0];
    endfunction

    assign s_axis_tready = (r_state == S_IDLE) && !r_m_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_free_cur    = free_of(r_last_off, r_count);
    assign w_free_next   = free_of(n_last_off, n_count);
    assign w_offs        = r_last_off - OW'(w_size);
    assign w_last_slot   = OW'(r_count - CW'(1));

    sps_ram #(.WIDTH(sps_pkg::BYTE_W), .DEPTH(PAGE_BYTES)) u_page (
        .i_clk   (i_clk),
        .i_we    (w_pg_we),
        .i_waddr (w_pg_waddr),
        .i_wdata (w_pg_wdata),
        .i_raddr (w_pg_raddr),
        .o_rdata (w_pg_rdata)
    );

    sps_ram #(.WIDTH(OW), .DEPTH(MAX_SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_sl_we),
        .i_waddr (w_sl_waddr),
        .i_wdata (w_sl_wdata),
        .i_raddr (w_sl_raddr),
        .o_rdata (w_sl_rdata)
    );

    sps_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    // Sequencer: decodes a transaction and walks sizes, bytes and slots.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last_off  = r_last_off;
        n_pend      = r_pend;
        n_pend_off  = r_pend_off;
        n_pend_size = r_pend_size;
        n_is_read   = r_is_read;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_off_i     = r_off_i;
        n_top       = r_top;
        n_size      = r_size;
        n_k         = r_k;
        n_i         = r_i;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;
        w_done      = 1'b0;
        w_status    = sps_pkg::ST_OK;
        w_slot      = '0;
        w_rbyte     = '0;
        w_ssize     = '0;
        w_pg_we     = 1'b0;
        w_pg_waddr  = '0;
        w_pg_wdata  = w_data;
        w_pg_raddr  = '0;
        w_sl_we     = 1'b0;
        w_sl_waddr  = '0;
        w_sl_wdata  = w_offs;
        w_sl_raddr  = '0;
        w_alu_req.op = sps_pkg::ALU_SUB;
        w_alu_req.a  = sps_pkg::ALU_W'(r_top);
        w_alu_req.b  = sps_pkg::ALU_W'(r_off_i);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx     = SW'(w_idx);
                    n_pos     = w_pos;
                    n_is_read = (w_kind == sps_pkg::KIND_READ);
                    w_slot    = w_idx;
                    w_sl_raddr = SW'(w_idx);
                    if (w_kind == sps_pkg::KIND_ADD) begin
                        w_done = 1'b1;
                        w_slot = '0;
                        if (w_pos == '0) begin
                            n_pend = 1'b0;
                            if (w_size == '0) begin
                                w_status = sps_pkg::ST_RANGE;
                            end else if (XW'(r_count) >= XW'(MAX_SLOTS) ||
                                         EW'(w_size) + EW'(SLOT_BYTES) > EW'(w_free_cur)) begin
                                w_status = sps_pkg::ST_NO_SPACE;
                            end else begin
                                w_sl_we     = 1'b1;
                                w_sl_waddr  = SW'(r_count);
                                w_pg_we     = 1'b1;
                                w_pg_waddr  = AW'(w_offs);
                                w_slot      = sps_pkg::INDEX_W'(r_count);
                                n_count     = r_count + CW'(1);
                                n_pend_off  = w_offs;
                                n_pend_size = w_size;
                                n_pend      = 1'b1;
                                n_last_off  = w_offs;
                            end
                        end else if (!r_pend || r_count == '0) begin
                            w_status = sps_pkg::ST_NO_SPACE;
                        end else begin
                            w_slot = sps_pkg::INDEX_W'(w_last_slot);
                            if (EW'(w_pos) >= EW'(r_pend_size)) begin
                                w_status = sps_pkg::ST_RANGE;
                            end else begin
                                w_pg_we    = 1'b1;
                                w_pg_waddr = AW'(r_pend_off + OW'(w_pos));
                            end
                        end
                    end else if (w_kind == sps_pkg::KIND_REMOVE ||
                                 w_kind == sps_pkg::KIND_READ) begin
                        if (w_kind == sps_pkg::KIND_REMOVE) begin
                            n_pend = 1'b0;
                        end
                        if (XW'(w_idx) >= XW'(r_count)) begin
                            w_done   = 1'b1;
                            w_status = sps_pkg::ST_RANGE;
                        end else begin
                            n_state = S_SLOT_A;
                        end
                    end else begin
                        w_done   = 1'b1;
                        w_slot   = '0;
                        w_status = sps_pkg::ST_RANGE;
                    end
                end
            end
            S_SLOT_A: begin
                n_off_i = w_sl_rdata;
                if (r_idx == '0) begin
                    n_top   = OW'(PAGE_BYTES);
                    n_state = S_SIZE;
                end else begin
                    w_sl_raddr = r_idx - SW'(1);
                    n_state    = S_SLOT_B;
                end
            end
            S_SLOT_B: begin
                n_top   = w_sl_rdata;
                n_state = S_SIZE;
            end
            S_SIZE: begin
                n_size = OW'(w_alu_res);
                w_slot = sps_pkg::INDEX_W'(r_idx);
                if (r_is_read) begin
                    if (EW'(r_pos) >= EW'(OW'(w_alu_res))) begin
                        w_done   = 1'b1;
                        w_status = sps_pkg::ST_RANGE;
                        w_ssize  = OW'(w_alu_res);
                        n_state  = S_IDLE;
                    end else begin
                        w_pg_raddr = AW'(r_off_i + OW'(r_pos));
                        n_state    = S_PAGE;
                    end
                end else if (OW'(r_idx) == w_last_slot) begin
                    w_done     = 1'b1;
                    n_count    = r_count - CW'(1);
                    n_last_off = r_top;
                    n_state    = S_IDLE;
                end else begin
                    n_k     = r_off_i - r_last_off;
                    n_state = S_CPY_RD;
                end
            end
            S_PAGE: begin
                w_done  = 1'b1;
                w_slot  = sps_pkg::INDEX_W'(r_idx);
                w_rbyte = w_pg_rdata;
                w_ssize = r_size;
                n_state = S_IDLE;
            end
            S_CPY_RD: begin
                if (r_k == '0) begin
                    n_i     = r_idx;
                    n_state = S_SL_RD;
                end else begin
                    w_pg_raddr = AW'(r_last_off + r_k - OW'(1));
                    n_state    = S_CPY_WR;
                end
            end
            S_CPY_WR: begin
                w_pg_we    = 1'b1;
                w_pg_waddr = AW'(r_last_off + r_size + r_k - OW'(1));
                w_pg_wdata = w_pg_rdata;
                n_k        = r_k - OW'(1);
                n_state    = S_CPY_RD;
            end
            S_SL_RD: begin
                if (OW'(r_i) == w_last_slot) begin
                    // Every moved object lies higher by the removed size.
                    w_alu_req.op = sps_pkg::ALU_ADD;
                    w_alu_req.a  = sps_pkg::ALU_W'(r_last_off);
                    w_alu_req.b  = sps_pkg::ALU_W'(r_size);
                    w_done       = 1'b1;
                    w_slot       = sps_pkg::INDEX_W'(r_idx);
                    n_last_off   = OW'(w_alu_res);
                    n_count      = r_count - CW'(1);
                    n_state      = S_IDLE;
                end else begin
                    w_sl_raddr = r_i + SW'(1);
                    n_state    = S_SL_WR;
                end
            end
            S_SL_WR: begin
                w_alu_req.op = sps_pkg::ALU_ADD;
                w_alu_req.a  = sps_pkg::ALU_W'(w_sl_rdata);
                w_alu_req.b  = sps_pkg::ALU_W'(r_size);
                w_sl_we      = 1'b1;
                w_sl_waddr   = r_i;
                w_sl_wdata   = OW'(w_alu_res);
                n_i          = r_i + SW'(1);
                n_state      = S_SL_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register when a transaction finishes.
        if (w_done) begin
            n_m_valid = 1'b1;
            n_m_user  = w_status;
            n_m_data  = {1'b0,
                         sps_pkg::COUNT_W'(n_count),
                         sps_pkg::SIZE_W'(w_free_next),
                         sps_pkg::SIZE_W'(w_ssize),
                         w_rbyte,
                         w_slot};
        end
    end

    // State, control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_last_off <= OW'(PAGE_BYTES);
            r_pend     <= 1'b0;
            r_pend_off <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_last_off <= n_last_off;
            r_pend     <= n_pend;
            r_pend_off <= n_pend_off;
            r_m_valid  <= n_m_valid;
        end
        r_pend_size <= n_pend_size;
        r_is_read   <= n_is_read;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_off_i     <= n_off_i;
        r_top       <= n_top;
        r_size      <= n_size;
        r_k         <= n_k;
        r_i         <= n_i;
        r_m_data    <= n_m_data;
        r_m_user    <= n_m_user;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

@@ sv/sps_checker.sv @@
`include "assert_macros.svh"

module sps_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [sps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [sps_pkg::KIND_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [sps_pkg::STATUS_W-1:0]   m_axis_tuser
);

    logic w_in_xact;
    logic w_out_hold;

    assign w_in_xact  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);
    assign w_out_hold = m_axis_tvalid && !m_axis_tready;

    // A new transaction is never taken while a result still waits.
    `SPS_ASSERT(a_no_overlap, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "input taken while result pending")
    // The block is busy in the cycle after it takes a transaction.
    `SPS_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, w_in_xact, !s_axis_tready, "ready right after a transaction")
    // Status is always one of the three defined codes.
    `SPS_ASSERT(a_status_code, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tuser == sps_pkg::ST_OK || m_axis_tuser == sps_pkg::ST_NO_SPACE || m_axis_tuser == sps_pkg::ST_RANGE, "undefined status code")
    // A stalled result holds its payload.
    `SPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_hold, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind slotted_page_store_unit sps_checker u_sps_checker (.*);
